FILE: sv/itb_pkg.sv
`default_nettype none
package itb_pkg;
  localparam int NumBatches = 64;
  localparam int BatchW = (NumBatches > 1) ? $clog2(NumBatches) : 1;
  localparam int BoundDepth = 3 * NumBatches;
  localparam int QueueDepth = 2;
  localparam int QueueAw = (QueueDepth > 1) ? $clog2(QueueDepth) : 1;
  localparam int QueueCntW = $clog2(QueueDepth + 1);
  localparam logic signed [31:0] S32Max = 32'sh7FFFFFFF;
  localparam logic signed [31:0] S32Min = 32'sh80000000;

  typedef struct packed {
    logic signed [15:0] qw;
    logic signed [15:0] qx;
    logic signed [15:0] qy;
    logic signed [15:0] qz;
    logic [15:0] sc;
    logic signed [31:0] px;
    logic signed [31:0] py;
    logic signed [31:0] pz;
    logic [15:0] rad;
    logic signed [15:0] ymin;
    logic signed [15:0] ymax;
    logic [5:0] bt;
    logic ok;
  } inst_t;

  typedef enum logic [2:0] {
    StIdle, StProd, StElem, StCorner, StEmit
  } back_st_e;

  // Saturate a wide signed value to 32 bits.
  function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
    if (v > 64'(S32Max)) return S32Max;
    if (v < 64'(S32Min)) return S32Min;
    return v[31:0];
  endfunction
endpackage
`default_nettype wire

FILE: sv/itb_front.sv
`default_nettype none
// Captures requests, flags batch range and buffers them in a short queue.
module itb_front (
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  input  wire logic         in_valid_i,
  output logic              in_stall_o,
  input  wire itb_pkg::inst_t in_req_i,
  output logic              q_valid_o,
  input  wire logic         q_pop_i,
  output itb_pkg::inst_t    q_req_o
);
  itb_pkg::inst_t mem_q [itb_pkg::QueueDepth];
  logic [itb_pkg::QueueAw-1:0] wp_q, rp_q;
  logic [itb_pkg::QueueCntW-1:0] cnt_q;
  logic push;
  itb_pkg::inst_t cls;

  assign in_stall_o = (cnt_q == itb_pkg::QueueCntW'(itb_pkg::QueueDepth));
  assign push = in_valid_i && !in_stall_o;
  assign q_valid_o = (cnt_q != '0);
  assign q_req_o = mem_q[rp_q];

  // Classify: mark batches that own state.
  always_comb begin
    cls = in_req_i;
    cls.ok = (32'(in_req_i.bt) < itb_pkg::NumBatches);
  end

  always_ff @(posedge clk_i) begin
    if (push) mem_q[wp_q] <= cls;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q <= '0; rp_q <= '0; cnt_q <= '0;
    end else begin
      if (push)
        wp_q <= (wp_q == itb_pkg::QueueAw'(itb_pkg::QueueDepth - 1))
                ? '0 : wp_q + itb_pkg::QueueAw'(1);
      if (q_pop_i)
        rp_q <= (rp_q == itb_pkg::QueueAw'(itb_pkg::QueueDepth - 1))
                ? '0 : rp_q + itb_pkg::QueueAw'(1);
      cnt_q <= cnt_q + itb_pkg::QueueCntW'(push) - itb_pkg::QueueCntW'(q_pop_i);
    end
  end
endmodule
`default_nettype wire

FILE: sv/itb_back.sv
`default_nettype none
// Builds the matrix, walks the eight corners and updates batch bounds.
module itb_back (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          q_valid_i,
  output logic               q_pop_o,
  input  wire itb_pkg::inst_t q_req_i,
  output logic               out_valid_o,
  input  wire logic          out_stall_i,
  output logic [5:0]         batch_out_o,
  output logic [1:0]         axis_o,
  output logic signed [31:0] m_col0_o,
  output logic signed [31:0] m_col1_o,
  output logic signed [31:0] m_col2_o,
  output logic signed [31:0] m_trans_o,
  output logic signed [31:0] box_min_o,
  output logic signed [31:0] box_max_o,
  output logic [15:0]        inst_count_o,
  output logic               last_o
);
  localparam logic signed [63:0] One = 64'sd1 <<< 28;

  itb_pkg::back_st_e st_q, st_d;
  itb_pkg::inst_t r_q;
  logic [3:0] step_q, step_d;
  logic [1:0] ax_q;
  logic signed [31:0] pr_q [9];
  logic signed [63:0] t_q [9];
  logic signed [31:0] m_q [9];
  logic signed [31:0] bmin_q [3];
  logic signed [31:0] bmax_q [3];
  logic [15:0] cnt_q;
  logic [15:0] cnt_mem_q [itb_pkg::NumBatches];
  // one valid bit per batch covers its count and all its bounds
  logic [itb_pkg::NumBatches-1:0] cnt_vld_q;
  // bounds, one store per axis and per min/max so each sees one access a cycle
  logic signed [31:0] bmin0_mem_q [itb_pkg::NumBatches];
  logic signed [31:0] bmin1_mem_q [itb_pkg::NumBatches];
  logic signed [31:0] bmin2_mem_q [itb_pkg::NumBatches];
  logic signed [31:0] bmax0_mem_q [itb_pkg::NumBatches];
  logic signed [31:0] bmax1_mem_q [itb_pkg::NumBatches];
  logic signed [31:0] bmax2_mem_q [itb_pkg::NumBatches];
  logic [itb_pkg::BatchW-1:0] bix;
  logic signed [16:0] lx, lz;
  logic signed [16:0] ly;
  logic signed [63:0] acc [3];
  logic signed [31:0] w [3];
  logic [3:0] ei;
  logic signed [63:0] ep;

  assign bix = r_q.bt[itb_pkg::BatchW-1:0];

  // Next state.
  always_comb begin
    st_d = st_q;
    step_d = step_q;
    unique case (st_q)
      itb_pkg::StIdle: if (q_valid_i) st_d = itb_pkg::StProd;
      itb_pkg::StProd: begin st_d = itb_pkg::StElem; step_d = 4'd0; end
      itb_pkg::StElem: begin
        step_d = step_q + 4'd1;
        if (step_q == 4'd8) begin st_d = itb_pkg::StCorner; step_d = 4'd0; end
      end
      itb_pkg::StCorner: begin
        step_d = step_q + 4'd1;
        if (step_q == 4'd7) st_d = itb_pkg::StEmit;
      end
      itb_pkg::StEmit:
        if (!out_stall_i && ax_q == 2'd2) st_d = itb_pkg::StIdle;
      default: st_d = itb_pkg::StIdle;
    endcase
  end

  // Outputs.
  always_comb begin
    q_pop_o = (st_q == itb_pkg::StIdle) && q_valid_i;
    out_valid_o = (st_q == itb_pkg::StEmit);
  end

  // Corner coordinates from the corner index.
  always_comb begin
    lx = step_q[0] ? $signed({1'b0, r_q.rad}) : -$signed({1'b0, r_q.rad});
    ly = step_q[1] ? 17'(r_q.ymax) : 17'(r_q.ymin);
    lz = step_q[2] ? $signed({1'b0, r_q.rad}) : -$signed({1'b0, r_q.rad});
    for (int a = 0; a < 3; a++) begin
      acc[a] = 64'(m_q[3*a]) * 64'(lx) + 64'(m_q[3*a+1]) * 64'(ly)
             + 64'(m_q[3*a+2]) * 64'(lz);
      w[a] = itb_pkg::sat32(((acc[a] + 64'sd128) >>> 8)
             + 64'(a == 0 ? r_q.px : (a == 1 ? r_q.py : r_q.pz)));
    end
    ei = step_q;
    ep = t_q[ei] * $signed({48'd0, r_q.sc});
  end

  always_ff @(posedge clk_i) begin
    unique case (st_q)
      itb_pkg::StIdle: if (q_valid_i) r_q <= q_req_i;
      itb_pkg::StProd: begin
        pr_q[0] <= r_q.qx * r_q.qx; pr_q[1] <= r_q.qy * r_q.qy;
        pr_q[2] <= r_q.qz * r_q.qz; pr_q[3] <= r_q.qx * r_q.qy;
        pr_q[4] <= r_q.qx * r_q.qz; pr_q[5] <= r_q.qy * r_q.qz;
        pr_q[6] <= r_q.qw * r_q.qx; pr_q[7] <= r_q.qw * r_q.qy;
        pr_q[8] <= r_q.qw * r_q.qz;
      end
      itb_pkg::StElem: begin
        if (step_q == 4'd0) begin
          t_q[0] <= One - 2 * (64'(pr_q[1]) + 64'(pr_q[2]));
          t_q[1] <= 2 * (64'(pr_q[3]) - 64'(pr_q[8]));
          t_q[2] <= 2 * (64'(pr_q[4]) + 64'(pr_q[7]));
          t_q[3] <= 2 * (64'(pr_q[3]) + 64'(pr_q[8]));
          t_q[4] <= One - 2 * (64'(pr_q[0]) + 64'(pr_q[2]));
          t_q[5] <= 2 * (64'(pr_q[5]) - 64'(pr_q[6]));
          t_q[6] <= 2 * (64'(pr_q[4]) - 64'(pr_q[7]));
          t_q[7] <= 2 * (64'(pr_q[5]) + 64'(pr_q[6]));
          t_q[8] <= One - 2 * (64'(pr_q[0]) + 64'(pr_q[1]));
          // count and bounds read, empty when the batch was never written
          if (!r_q.ok) cnt_q <= 16'd0;
          else if (!cnt_vld_q[bix]) cnt_q <= 16'd1;
          else if (cnt_mem_q[bix] != 16'hFFFF) cnt_q <= cnt_mem_q[bix] + 16'd1;
          else cnt_q <= 16'hFFFF;
          bmin_q[0] <= (r_q.ok && cnt_vld_q[bix]) ? bmin0_mem_q[bix] : itb_pkg::S32Max;
          bmin_q[1] <= (r_q.ok && cnt_vld_q[bix]) ? bmin1_mem_q[bix] : itb_pkg::S32Max;
          bmin_q[2] <= (r_q.ok && cnt_vld_q[bix]) ? bmin2_mem_q[bix] : itb_pkg::S32Max;
          bmax_q[0] <= (r_q.ok && cnt_vld_q[bix]) ? bmax0_mem_q[bix] : itb_pkg::S32Min;
          bmax_q[1] <= (r_q.ok && cnt_vld_q[bix]) ? bmax1_mem_q[bix] : itb_pkg::S32Min;
          bmax_q[2] <= (r_q.ok && cnt_vld_q[bix]) ? bmax2_mem_q[bix] : itb_pkg::S32Min;
        end
        if (step_q != 4'd0)
          m_q[step_q - 4'd1] <= itb_pkg::sat32((t_q[step_q - 4'd1]
            * $signed({48'd0, r_q.sc}) + (64'sd1 <<< 27)) >>> 28);
        if (step_q == 4'd8) m_q[8] <= itb_pkg::sat32((ep + (64'sd1 <<< 27)) >>> 28);
      end
      itb_pkg::StCorner: if (r_q.ok) begin
        for (int a = 0; a < 3; a++) begin
          if (w[a] < bmin_q[a]) bmin_q[a] <= w[a];
          if (w[a] > bmax_q[a]) bmax_q[a] <= w[a];
        end
      end
      default: ;
    endcase
    if (st_q == itb_pkg::StCorner && step_q == 4'd7 && r_q.ok) begin
      cnt_mem_q[bix] <= cnt_q;
      bmin0_mem_q[bix] <= (w[0] < bmin_q[0]) ? w[0] : bmin_q[0];
      bmin1_mem_q[bix] <= (w[1] < bmin_q[1]) ? w[1] : bmin_q[1];
      bmin2_mem_q[bix] <= (w[2] < bmin_q[2]) ? w[2] : bmin_q[2];
      bmax0_mem_q[bix] <= (w[0] > bmax_q[0]) ? w[0] : bmax_q[0];
      bmax1_mem_q[bix] <= (w[1] > bmax_q[1]) ? w[1] : bmax_q[1];
      bmax2_mem_q[bix] <= (w[2] > bmax_q[2]) ? w[2] : bmax_q[2];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= itb_pkg::StIdle;
      step_q <= 4'd0;
      ax_q <= 2'd0;
      cnt_vld_q <= '0;
    end else begin
      st_q <= st_d;
      step_q <= step_d;
      if (st_q == itb_pkg::StEmit && !out_stall_i)
        ax_q <= (ax_q == 2'd2) ? 2'd0 : ax_q + 2'd1;
      if (st_q == itb_pkg::StCorner && step_q == 4'd7 && r_q.ok)
        cnt_vld_q[bix] <= 1'b1;
    end
  end

  assign batch_out_o = r_q.bt;
  assign axis_o = ax_q;
  assign m_col0_o = m_q[3*ax_q];
  assign m_col1_o = m_q[3*ax_q+1];
  assign m_col2_o = m_q[3*ax_q+2];
  assign m_trans_o = (ax_q == 2'd0) ? r_q.px : ((ax_q == 2'd1) ? r_q.py : r_q.pz);
  assign box_min_o = bmin_q[ax_q];
  assign box_max_o = bmax_q[ax_q];
  assign inst_count_o = cnt_q;
  assign last_o = (ax_q == 2'd2);
endmodule
`default_nettype wire

FILE: sv/instance_transform_bounds.sv
`default_nettype none
// channel | handshake               | payload
// in      | in_valid_i/in_stall_o   | quaternion, scale, position, extent, batch
// out     | out_valid_o/out_stall_i | one matrix row and bounds per axis
// An instance passes through a pop, a product step, the element steps
// (terms, then scaling), one corner step per box corner and three result
// rows, each held while stalled. The next request is popped after the last row.
// A two-entry queue accepts requests while the back end works, stalling when full.
// Reset clears one valid bit per batch at once; no clearing pass.
module instance_transform_bounds (
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  input  wire logic         in_valid_i,
  output logic              in_stall_o,
  input  wire logic signed [15:0] quat_w_i,
  input  wire logic signed [15:0] quat_x_i,
  input  wire logic signed [15:0] quat_y_i,
  input  wire logic signed [15:0] quat_z_i,
  input  wire logic [15:0]  inst_scale_i,
  input  wire logic signed [31:0] pos_x_i,
  input  wire logic signed [31:0] pos_y_i,
  input  wire logic signed [31:0] pos_z_i,
  input  wire logic [15:0]  radius_xz_i,
  input  wire logic signed [15:0] local_min_y_i,
  input  wire logic signed [15:0] local_max_y_i,
  input  wire logic [5:0]   batch_i,
  output logic              out_valid_o,
  input  wire logic         out_stall_i,
  output logic [5:0]        batch_out_o,
  output logic [1:0]        axis_o,
  output logic signed [31:0] m_col0_o,
  output logic signed [31:0] m_col1_o,
  output logic signed [31:0] m_col2_o,
  output logic signed [31:0] m_trans_o,
  output logic signed [31:0] box_min_o,
  output logic signed [31:0] box_max_o,
  output logic [15:0]       inst_count_o,
  output logic              last_o
);
  itb_pkg::inst_t req, qreq;
  logic qv, pop;

  always_comb begin
    req.qw = quat_w_i; req.qx = quat_x_i; req.qy = quat_y_i; req.qz = quat_z_i;
    req.sc = inst_scale_i; req.px = pos_x_i; req.py = pos_y_i; req.pz = pos_z_i;
    req.rad = radius_xz_i; req.ymin = local_min_y_i; req.ymax = local_max_y_i;
    req.bt = batch_i; req.ok = 1'b0;
  end

  itb_front u_front (.clk_i, .rst_ni, .in_valid_i, .in_stall_o, .in_req_i(req),
    .q_valid_o(qv), .q_pop_i(pop), .q_req_o(qreq));

  itb_back u_back (.clk_i, .rst_ni, .q_valid_i(qv), .q_pop_o(pop), .q_req_i(qreq),
    .out_valid_o, .out_stall_i, .batch_out_o, .axis_o, .m_col0_o, .m_col1_o,
    .m_col2_o, .m_trans_o, .box_min_o, .box_max_o, .inst_count_o, .last_o);
endmodule
`default_nettype wire

FILE: dv/instance_transform_bounds_tb.sv
`timescale 1ns / 100ps
module instance_transform_bounds_tb;

  typedef struct {
    logic signed [15:0] qw, qx, qy, qz;
    logic [15:0] sc;
    logic signed [31:0] px, py, pz;
    logic [15:0] rad;
    logic signed [15:0] ymin, ymax;
    logic [5:0] bt;
  } request_t;

  typedef struct {
    logic [5:0] bt;
    logic [1:0] axis;
    logic signed [31:0] c0, c1, c2, tr, bmin, bmax;
    logic [15:0] cnt;
    logic last;
  } row_t;

  logic clk, rst_n;
  logic in_valid, in_stall, out_valid, out_stall;
  request_t drv;
  logic [5:0] batch_out;
  logic [1:0] axis;
  logic signed [31:0] m_col0, m_col1, m_col2, m_trans, box_min, box_max;
  logic [15:0] inst_count;
  logic last;

  request_t pending_q[$];
  row_t expected_rows_q[$];
  logic signed [31:0] world_min[itb_pkg::BoundDepth];
  logic signed [31:0] world_max[itb_pkg::BoundDepth];
  logic [15:0] inst_total[itb_pkg::NumBatches];
  int errors = 0;
  bit stim_done = 0;
  int burst_left = 0, gap_left = 0;
  int hold_off = 0;
  int stall_phase = 0;

  instance_transform_bounds i_dut (
    .clk_i(clk), .rst_ni(rst_n),
    .in_valid_i(in_valid), .in_stall_o(in_stall),
    .quat_w_i(drv.qw), .quat_x_i(drv.qx), .quat_y_i(drv.qy), .quat_z_i(drv.qz),
    .inst_scale_i(drv.sc), .pos_x_i(drv.px), .pos_y_i(drv.py), .pos_z_i(drv.pz),
    .radius_xz_i(drv.rad), .local_min_y_i(drv.ymin), .local_max_y_i(drv.ymax),
    .batch_i(drv.bt),
    .out_valid_o(out_valid), .out_stall_i(out_stall),
    .batch_out_o(batch_out), .axis_o(axis), .m_col0_o(m_col0), .m_col1_o(m_col1),
    .m_col2_o(m_col2), .m_trans_o(m_trans), .box_min_o(box_min), .box_max_o(box_max),
    .inst_count_o(inst_count), .last_o(last)
  );

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  // Round to nearest, ties toward +inf (arithmetic shift floors).
  function automatic longint round_down(longint v, int n);
    return (v + (longint'(1) << (n - 1))) >>> n;
  endfunction

  function automatic logic signed [31:0] clamp32(longint v);
    if (v > 64'sd2147483647) return itb_pkg::S32Max;
    if (v < -64'sd2147483648) return itb_pkg::S32Min;
    return v[31:0];
  endfunction

  // Matrix rows, corner transform and batch bounds update for one request.
  function automatic void predict_rows(request_t r);
    longint qw, qx, qy, qz, sc, one, lx, ly, lz, acc;
    longint t[3][3];
    logic signed [31:0] m[3][3];
    longint pos[3];
    logic signed [31:0] w;
    logic [15:0] cnt;
    row_t row;
    int k;
    qw = r.qw; qx = r.qx; qy = r.qy; qz = r.qz;
    sc = r.sc;
    one = longint'(1) << 28;
    pos[0] = r.px; pos[1] = r.py; pos[2] = r.pz;
    t[0][0] = one - 2 * (qy*qy + qz*qz); t[0][1] = 2 * (qx*qy - qw*qz);
    t[0][2] = 2 * (qx*qz + qw*qy);
    t[1][0] = 2 * (qx*qy + qw*qz); t[1][1] = one - 2 * (qx*qx + qz*qz);
    t[1][2] = 2 * (qy*qz - qw*qx);
    t[2][0] = 2 * (qx*qz - qw*qy); t[2][1] = 2 * (qy*qz + qw*qx);
    t[2][2] = one - 2 * (qx*qx + qy*qy);
    for (int a = 0; a < 3; a++)
      for (int c = 0; c < 3; c++)
        m[a][c] = clamp32(round_down(t[a][c] * sc, 28));
    if (inst_total[r.bt] != 16'hFFFF) inst_total[r.bt]++;
    cnt = inst_total[r.bt];
    for (int corner = 0; corner < 8; corner++) begin
      lx = (corner & 1) ? longint'(r.rad) : -longint'(r.rad);
      ly = (corner & 2) ? longint'(r.ymax) : longint'(r.ymin);
      lz = (corner & 4) ? longint'(r.rad) : -longint'(r.rad);
      for (int a = 0; a < 3; a++) begin
        acc = longint'(m[a][0]) * lx + longint'(m[a][1]) * ly + longint'(m[a][2]) * lz;
        w = clamp32(round_down(acc, 8) + pos[a]);
        k = r.bt * 3 + a;
        if (w < world_min[k]) world_min[k] = w;
        if (w > world_max[k]) world_max[k] = w;
      end
    end
    for (int a = 0; a < 3; a++) begin
      row.bt = r.bt; row.axis = 2'(a);
      row.c0 = m[a][0]; row.c1 = m[a][1]; row.c2 = m[a][2];
      row.tr = pos[a][31:0];
      row.bmin = world_min[r.bt * 3 + a]; row.bmax = world_max[r.bt * 3 + a];
      row.cnt = cnt; row.last = (a == 2);
      expected_rows_q.insert(expected_rows_q.size(), row);
    end
  endfunction

  task automatic report(string what, logic [31:0] got, logic [31:0] want);
    $display("mismatch %s: got %h want %h", what, got, want);
    errors++;
  endtask

  function automatic void add_req(request_t r);
    pending_q.insert(pending_q.size(), r);
  endfunction

  function automatic request_t rand_request();
    request_t r;
    int mode;
    mode = $urandom_range(0, 9);
    // mostly quaternion components within +-1.0 with modest extents; some full-range noise
    if (mode < 7) begin
      r.qw = $signed(16'($urandom_range(0, 32768))) - 16'sd16384;
      r.qx = $signed(16'($urandom_range(0, 32768))) - 16'sd16384;
      r.qy = $signed(16'($urandom_range(0, 32768))) - 16'sd16384;
      r.qz = $signed(16'($urandom_range(0, 32768))) - 16'sd16384;
      r.sc = 16'($urandom_range(0, 1024));
      r.px = $signed($urandom_range(0, 32'h00FFFFFF)) - 32'sh00800000;
      r.py = $signed($urandom_range(0, 32'h00FFFFFF)) - 32'sh00800000;
      r.pz = $signed($urandom_range(0, 32'h00FFFFFF)) - 32'sh00800000;
      r.rad = 16'($urandom_range(0, 4096));
      r.ymin = -$signed(16'($urandom_range(0, 2048)));
      r.ymax = 16'($urandom_range(0, 4096));
      r.bt = 6'($urandom_range(0, 7));
    end else begin
      {r.qw, r.qx, r.qy, r.qz, r.sc} = 80'({$urandom, $urandom, $urandom});
      {r.px, r.py, r.pz} = {$urandom, $urandom, $urandom};
      {r.rad, r.ymin, r.ymax} = 48'({$urandom, $urandom});
      r.bt = 6'($urandom);
    end
    return r;
  endfunction

  function automatic request_t make_req(int qw, qx, qy, qz, int sc, int p,
                                        int rad, int y0, y1, int bt);
    request_t r;
    r.qw = 16'(qw); r.qx = 16'(qx); r.qy = 16'(qy); r.qz = 16'(qz); r.sc = 16'(sc);
    r.px = p; r.py = -p; r.pz = p;
    r.rad = 16'(rad); r.ymin = 16'(y0); r.ymax = 16'(y1); r.bt = 6'(bt);
    return r;
  endfunction

  // Directed then random stimulus
  initial begin
    for (int i = 0; i < itb_pkg::BoundDepth; i++) begin
      world_min[i] = itb_pkg::S32Max;
      world_max[i] = itb_pkg::S32Min;
    end
    for (int i = 0; i < itb_pkg::NumBatches; i++) inst_total[i] = 0;
    // identity, unit scale
    add_req(make_req(16384, 0, 0, 0, 256, 0, 256, -256, 256, 0));
    // 90 degree turns about each axis
    add_req(make_req(11585, 11585, 0, 0, 512, 1000, 300, 0, 700, 1));
    add_req(make_req(11585, 0, 11585, 0, 256, -1000, 300, 0, 700, 1));
    add_req(make_req(11585, 0, 0, 11585, 256, 5, 300, 0, 700, 2));
    // extreme components, non-unit quaternion, saturation
    add_req(make_req(-16384, -16384, -16384, -16384, 65535,
                     32'sh7FFFFFFF, 65535, -32768, 32767, 3));
    add_req(make_req(16384, 16384, 16384, 16384, 65535,
                     32'sh80000000, 65535, 32767, -32768, 3));
    add_req(make_req(-32768, 32767, -32768, 32767, 65535,
                     32'sh80000000, 65535, -32768, 32767, 4));
    // zero scale, zero extent
    add_req(make_req(16384, 0, 0, 0, 0, 123, 0, 0, 0, 5));
    // local min above local max
    add_req(make_req(16384, 0, 0, 0, 256, 0, 100, 500, -500, 6));
    // highest batch
    add_req(make_req(0, 16384, 0, 0, 300, 77, 50, -5, 9, 63));
    add_req(make_req(0, 0, 16384, 0, 300, -77, 50, -5, 9, 63));
    // rounding ties
    add_req(make_req(1, 1, 1, 1, 1, -1, 1, -1, 1, 7));
    for (int i = 0; i < 418; i++) add_req(rand_request());
    // count saturation on one batch is out of reach in 430 items; batches
    // 0 to 7 still see many repeats through the random batch spread
    stim_done = 1;
  end

  // Driver: bursts and gaps, payload held while stalled
  always @(posedge clk or negedge rst_n) begin
    if (!rst_n) begin
      in_valid <= 0;
      drv <= '{default: '0};
      burst_left <= 0;
      gap_left <= 0;
    end else if (!in_valid || !in_stall) begin
      if (gap_left > 0) begin
        gap_left <= gap_left - 1;
        in_valid <= 0;
      end else if (pending_q.size() > 0) begin
        drv <= pending_q.pop_front();
        in_valid <= 1;
        if (burst_left <= 1) begin
          burst_left <= $urandom_range(1, 30);
          gap_left <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
        end else begin
          burst_left <= burst_left - 1;
        end
      end else begin
        in_valid <= 0;
      end
    end
  end

  // Predict at acceptance time so order matches
  always @(posedge clk) begin
    if (rst_n && in_valid && !in_stall) predict_rows(drv);
  end

  // Long hold-off early on, counted down in cycles
  always @(posedge clk or negedge rst_n) begin
    if (!rst_n) begin
      hold_off <= 0;
    end else if (stall_phase == 200) begin
      hold_off <= 300;
    end else if (hold_off > 0) begin
      hold_off <= hold_off - 1;
    end
  end

  // Receiver stall pattern
  always @(posedge clk or negedge rst_n) begin
    if (!rst_n) begin
      out_stall <= 0;
      stall_phase <= 0;
    end else begin
      stall_phase <= stall_phase + 1;
      if (hold_off > 0) begin
        out_stall <= 1;
      end else if ((stall_phase / 64) % 3 == 0) begin
        out_stall <= 0;
      end else begin
        out_stall <= ($urandom_range(0, 3) == 0);
      end
    end
  end

  // Monitor: compare each accepted row with the oldest expectation
  always @(posedge clk) begin
    row_t e;
    if (rst_n && out_valid && !out_stall) begin
      if (expected_rows_q.size() == 0) begin
        report("unexpected row", 32'(batch_out), 32'd0);
      end else begin
        e = expected_rows_q.pop_front();
        if (batch_out !== e.bt) report("batch_out", 32'(batch_out), 32'(e.bt));
        if (axis !== e.axis) report("axis", 32'(axis), 32'(e.axis));
        if (m_col0 !== e.c0) report("m_col0", m_col0, e.c0);
        if (m_col1 !== e.c1) report("m_col1", m_col1, e.c1);
        if (m_col2 !== e.c2) report("m_col2", m_col2, e.c2);
        if (m_trans !== e.tr) report("m_trans", m_trans, e.tr);
        if (box_min !== e.bmin) report("box_min", box_min, e.bmin);
        if (box_max !== e.bmax) report("box_max", box_max, e.bmax);
        if (inst_count !== e.cnt) report("inst_count", 32'(inst_count), 32'(e.cnt));
        if (last !== e.last) report("last", 32'(last), 32'(e.last));
      end
    end
  end

  // Reset, then wait for drain
  initial begin
    rst_n = 0;
    repeat (9) @(posedge clk);
    rst_n <= 1;
    wait (stim_done && pending_q.size() == 0);
    @(posedge clk);
    wait (!in_valid && expected_rows_q.size() == 0);
    repeat (50) @(posedge clk);
    if (errors == 0) $display("status: pass");
    else $display("status: fail");
    $finish;
  end

  initial begin
    #2000000;
    $display("status: fail");
    $finish;
  end
endmodule
